FILE: design/sds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sds_pkg;

    localparam int STEPS_W         = 24;
    localparam int DUR_W           = 32;
    localparam int COIL_W          = 4;
    localparam int NUM_W           = DUR_W + 2;
    localparam int STEP_BITS_DEF   = 24;
    localparam int PERIOD_BITS_DEF = 32;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_MOVE = 2'd1,
        OP_STOP = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_right;
        logic take_left;
        logic take_right;
        logic apply;
        logic emit;
    } sds_cmd_t;

    typedef struct packed {
        logic is_move;
        logic div_done;
        logic out_free;
    } sds_sts_t;

endpackage

`default_nettype wire

FILE: design/sds_div.sv
`timescale 1ns / 1ps
`default_nettype none

module sds_div
    import sds_pkg::*;
#(
    parameter int DEN_W = STEP_BITS_DEF + 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             done_reg;
    logic             done_next;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] num_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] den_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   den_ext;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign den_ext = {1'b0, den_reg};
    assign ge      = shifted >= den_ext;
    assign diff    = shifted - den_ext;

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            cnt_next = CNT_W'(NUM_W);
            num_next = num;
            rem_next = '0;
            den_next = den;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
            num_next  = {num_reg[NUM_W-2:0], ge};
            rem_next  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

`default_nettype wire

FILE: design/sds_motor.sv
`timescale 1ns / 1ps
`default_nettype none

module sds_motor
    import sds_pkg::*;
#(
    parameter int STEP_BITS   = STEP_BITS_DEF,
    parameter int PERIOD_BITS = PERIOD_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      apply,
    input  wire op_t                       op,
    input  wire logic signed [STEPS_W-1:0] steps,
    input  wire logic                      invert,
    input  wire logic [PERIOD_BITS-1:0]    period_in,
    output logic [STEP_BITS-1:0]           mag,
    output logic [COIL_W-1:0]              coils,
    output logic                           busy
);

    localparam int PHASE_W = 3;
    localparam logic [COIL_W-1:0] HALF_STEP [0:7] =
        '{4'd8, 4'd12, 4'd4, 4'd6, 4'd2, 4'd3, 4'd1, 4'd9};

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd3
    } dir_t;

    logic [PHASE_W-1:0]     phase_reg;
    logic [PHASE_W-1:0]     phase_next;
    dir_t                   dir_reg;
    dir_t                   dir_next;
    logic [STEP_BITS-1:0]   count_reg;
    logic [STEP_BITS-1:0]   count_next;
    logic [STEP_BITS-1:0]   target_reg;
    logic [STEP_BITS-1:0]   target_next;
    logic [PERIOD_BITS-1:0] period_reg;
    logic [PERIOD_BITS-1:0] period_next;
    logic [PERIOD_BITS-1:0] elapsed_reg;
    logic [PERIOD_BITS-1:0] elapsed_next;
    logic [PERIOD_BITS-1:0] elapsed_inc;
    logic [COIL_W-1:0]      drive_reg;
    logic [COIL_W-1:0]      drive_next;
    logic [STEPS_W-1:0]     steps_u;
    logic [STEPS_W-1:0]     mag_full;
    logic                   neg;
    logic                   fwd;

    assign steps_u  = steps;
    assign neg      = steps_u[STEPS_W-1];
    assign mag_full = neg ? (~steps_u + 1'b1) : steps_u;
    assign fwd      = (!neg) ^ invert;

    generate
        if (STEP_BITS >= STEPS_W)
        begin : g_wide
            assign mag = STEP_BITS'(mag_full);
        end
        else
        begin : g_sat
            assign mag = (|mag_full[STEPS_W-1:STEP_BITS]) ? '1 : mag_full[STEP_BITS-1:0];
        end
    endgenerate

    assign elapsed_inc = elapsed_reg + 1'b1;

    always_comb
    begin
        phase_next   = phase_reg;
        dir_next     = dir_reg;
        count_next   = count_reg;
        target_next  = target_reg;
        period_next  = period_reg;
        elapsed_next = elapsed_reg;
        drive_next   = drive_reg;
        if (apply)
        begin
            case (op)
                OP_TICK:
                begin
                    if (dir_reg != DIR_STOP)
                    begin
                        if (elapsed_inc < period_reg)
                        begin
                            elapsed_next = elapsed_inc;
                        end
                        else
                        begin
                            elapsed_next = '0;
                            if (count_reg >= target_reg)
                            begin
                                dir_next   = DIR_STOP;
                                drive_next = '0;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                drive_next = HALF_STEP[phase_reg];
                                phase_next = (dir_reg == DIR_FWD) ? phase_reg + 1'b1
                                                                  : phase_reg - 1'b1;
                            end
                        end
                    end
                end
                OP_MOVE:
                begin
                    if (steps_u == '0)
                    begin
                        dir_next     = DIR_STOP;
                        drive_next   = '0;
                        count_next   = '0;
                        elapsed_next = '0;
                    end
                    else
                    begin
                        period_next  = period_in;
                        target_next  = mag;
                        count_next   = '0;
                        elapsed_next = '0;
                        dir_next     = fwd ? DIR_FWD : DIR_REV;
                    end
                end
                OP_STOP:
                begin
                    dir_next     = DIR_STOP;
                    drive_next   = '0;
                    count_next   = '0;
                    elapsed_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            dir_reg     <= DIR_STOP;
            count_reg   <= '0;
            target_reg  <= '0;
            period_reg  <= PERIOD_BITS'(1);
            elapsed_reg <= '0;
            drive_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            dir_reg     <= dir_next;
            count_reg   <= count_next;
            target_reg  <= target_next;
            period_reg  <= period_next;
            elapsed_reg <= elapsed_next;
            drive_reg   <= drive_next;
        end
    end

    assign coils = drive_reg;
    assign busy  = (dir_reg != DIR_STOP);

endmodule

`default_nettype wire

FILE: design/sds_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module sds_dpath
    import sds_pkg::*;
#(
    parameter int STEP_BITS   = STEP_BITS_DEF,
    parameter int PERIOD_BITS = PERIOD_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire sds_cmd_t                  cmd,
    output sds_sts_t                       sts,
    input  wire logic [1:0]                op,
    input  wire logic signed [STEPS_W-1:0] left_steps,
    input  wire logic signed [STEPS_W-1:0] right_steps,
    input  wire logic [DUR_W-1:0]          duration_us,
    input  wire logic                      cfg_valid,
    input  wire logic                      cfg_data,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [COIL_W-1:0]              left_coils,
    output logic [COIL_W-1:0]              right_coils,
    output logic                           left_busy,
    output logic                           right_busy,
    output logic                           moving
);

    localparam int DEN_W = STEP_BITS + 1;

    op_t                        op_reg;
    logic signed [STEPS_W-1:0]  lsteps_reg;
    logic signed [STEPS_W-1:0]  rsteps_reg;
    logic [DUR_W-1:0]           dur_reg;
    logic                       rev_reg;
    logic [PERIOD_BITS-1:0]     lper_reg;
    logic [PERIOD_BITS-1:0]     rper_reg;
    logic [PERIOD_BITS-1:0]     q_sat;
    logic [STEP_BITS-1:0]       lmag;
    logic [STEP_BITS-1:0]       rmag;
    logic [STEP_BITS-1:0]       mag_sel;
    logic [NUM_W-1:0]           div_num;
    logic [DEN_W-1:0]           div_den;
    logic [NUM_W-1:0]           quot;
    logic                       div_done;
    logic [COIL_W-1:0]          lcoils;
    logic [COIL_W-1:0]          rcoils;
    logic                       lbusy;
    logic                       rbusy;
    logic                       out_valid_reg;
    logic [COIL_W-1:0]          lcoils_reg;
    logic [COIL_W-1:0]          rcoils_reg;
    logic                       lbusy_reg;
    logic                       rbusy_reg;

    // hold the word until the sequence is done
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op_t'(op);
            lsteps_reg <= left_steps;
            rsteps_reg <= right_steps;
            dur_reg    <= duration_us;
        end
        if (cmd.take_left)
        begin
            lper_reg <= q_sat;
        end
        if (cmd.take_right)
        begin
            rper_reg <= q_sat;
        end
        if (cmd.emit)
        begin
            lcoils_reg <= lcoils;
            rcoils_reg <= rcoils;
            lbusy_reg  <= lbusy;
            rbusy_reg  <= rbusy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rev_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                rev_reg <= cfg_data;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // period = (2*duration + s) / (2*s), rounded to nearest
    assign mag_sel = cmd.div_right ? rmag : lmag;
    assign div_num = {1'b0, dur_reg, 1'b0} + NUM_W'(mag_sel);
    assign div_den = {mag_sel, 1'b0};

    always_comb
    begin
        if (|quot[NUM_W-1:PERIOD_BITS])
        begin
            q_sat = '1;
        end
        else if (quot == '0)
        begin
            q_sat = PERIOD_BITS'(1);
        end
        else
        begin
            q_sat = quot[PERIOD_BITS-1:0];
        end
    end

    sds_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (quot)
    );

    sds_motor #(
        .STEP_BITS   (STEP_BITS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .apply     (cmd.apply),
        .op        (op_reg),
        .steps     (lsteps_reg),
        .invert    (1'b0),
        .period_in (lper_reg),
        .mag       (lmag),
        .coils     (lcoils),
        .busy      (lbusy)
    );

    sds_motor #(
        .STEP_BITS   (STEP_BITS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .apply     (cmd.apply),
        .op        (op_reg),
        .steps     (rsteps_reg),
        .invert    (rev_reg),
        .period_in (rper_reg),
        .mag       (rmag),
        .coils     (rcoils),
        .busy      (rbusy)
    );

    assign sts.is_move  = (op_reg == OP_MOVE);
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign left_coils  = lcoils_reg;
    assign right_coils = rcoils_reg;
    assign left_busy   = lbusy_reg;
    assign right_busy  = rbusy_reg;
    assign moving      = lbusy_reg | rbusy_reg;

endmodule

`default_nettype wire

FILE: design/sds_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sds_ctrl
    import sds_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          ready,
    input  wire sds_sts_t sts,
    output sds_cmd_t      cmd
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DISPATCH = 6'b000010,
        ST_DIV_L    = 6'b000100,
        ST_DIV_R    = 6'b001000,
        ST_APPLY    = 6'b010000,
        ST_EMIT     = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        ready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (sts.is_move)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_L;
                end
                else
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_DIV_L:
            begin
                if (sts.div_done)
                begin
                    cmd.take_left = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_right = 1'b1;
                    state_next    = ST_DIV_R;
                end
            end
            ST_DIV_R:
            begin
                if (sts.div_done)
                begin
                    cmd.take_right = 1'b1;
                    state_next     = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/dual_stepper_timed_half_step_driver.sv
// Two-motor half-step stepper driver with timed moves.
// Input channel (in_valid/in_stall) takes one word per item: op selects a
// one-microsecond tick, a move command, a stop or no action; a move carries signed
// step counts per motor and the move duration in microseconds.
// Output channel (out_valid/out_stall) returns one word per item with the
// coil drive bits and busy flags as they stand after that item.
// Configuration channel (cfg_valid/cfg_ready, always ready) writes
// right_reverse; write it only while no item is in flight.
// Sequence: tick, stop and unused op go through dispatch, apply and emit
// after acceptance; a move also runs the radix-2 divider that works out
// the step interval, once per motor, one motor after the other, before
// apply. One item is handled at a time; the next is taken the cycle
// after the previous result is registered.
// Reset clears both motors (coils off, stopped) and sets right_reverse.
// A stalled result holds in the output register; the next item may still
// be accepted and worked on, and waits for the slot before it is shown.
`timescale 1ns / 1ps
`default_nettype none

module dual_stepper_timed_half_step_driver
    import sds_pkg::*;
#(
    parameter int STEP_BITS   = STEP_BITS_DEF,
    parameter int PERIOD_BITS = PERIOD_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [1:0]                op,
    input  wire logic signed [STEPS_W-1:0] left_steps,
    input  wire logic signed [STEPS_W-1:0] right_steps,
    input  wire logic [DUR_W-1:0]          duration_us,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [COIL_W-1:0]              left_coils,
    output logic [COIL_W-1:0]              right_coils,
    output logic                           left_busy,
    output logic                           right_busy,
    output logic                           moving,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic                      cfg_data
);

    sds_cmd_t cmd;
    sds_sts_t sts;
    logic     ready;

    assign in_stall  = ~ready;
    assign cfg_ready = 1'b1;

    sds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .ready    (ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sds_dpath #(
        .STEP_BITS   (STEP_BITS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .op          (op),
        .left_steps  (left_steps),
        .right_steps (right_steps),
        .duration_us (duration_us),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .left_coils  (left_coils),
        .right_coils (right_coils),
        .left_busy   (left_busy),
        .right_busy  (right_busy),
        .moving      (moving)
    );

endmodule

`default_nettype wire

FILE: design/sds_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module sds_chk
    import sds_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_stall,
    input wire logic                      out_valid,
    input wire logic                      out_stall,
    input wire logic [COIL_W-1:0]         left_coils,
    input wire logic [COIL_W-1:0]         right_coils,
    input wire logic                      left_busy,
    input wire logic                      right_busy,
    input wire logic                      moving
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(left_coils)
            && $stable(right_coils) && $stable(left_busy) && $stable(right_busy))
        else $error("stalled result word changed");

    a_moving: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> moving == (left_busy || right_busy))
        else $error("moving does not match busy flags");

    a_left_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !left_busy |-> left_coils == '0)
        else $error("left coils driven while stopped");

    a_right_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !right_busy |-> right_coils == '0)
        else $error("right coils driven while stopped");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word taken while an item is in flight");

endmodule

bind dual_stepper_timed_half_step_driver sds_chk u_chk (.*);

`default_nettype wire

FILE: tb/sv/tb_dual_stepper_timed_half_step_driver.sv
`timescale 1ns / 1ps

module tb_dual_stepper_timed_half_step_driver;
    import sds_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 900000;
    localparam int SETTLE_CYCLES = 100;
    localparam int MAX_REPORTS   = 10;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd3;

    typedef struct packed {
        logic [2:0]         phase;
        logic [1:0]         dir;
        logic [STEPS_W-1:0] count;
        logic [STEPS_W-1:0] target;
        logic [DUR_W-1:0]   period;
        logic [DUR_W-1:0]   elapsed;
        logic [COIL_W-1:0]  drive;
    } motor_t;

    typedef struct packed {
        logic [COIL_W-1:0] left_coils;
        logic [COIL_W-1:0] right_coils;
        logic              left_busy;
        logic              right_busy;
        logic              moving;
    } coil_word_t;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      in_valid    = 1'b0;
    logic                      in_stall;
    logic [1:0]                op          = OP_TICK;
    logic signed [STEPS_W-1:0] left_steps  = '0;
    logic signed [STEPS_W-1:0] right_steps = '0;
    logic [DUR_W-1:0]          duration_us = '0;
    logic                      out_valid;
    logic                      out_stall   = 1'b0;
    logic [COIL_W-1:0]         left_coils;
    logic [COIL_W-1:0]         right_coils;
    logic                      left_busy;
    logic                      right_busy;
    logic                      moving;
    logic                      cfg_valid   = 1'b0;
    logic                      cfg_ready;
    logic                      cfg_data    = 1'b0;

    motor_t     left_m;
    motor_t     right_m;
    logic       mirror_right;
    coil_word_t coil_words_q[$];
    int         mismatches = 0;
    int         cycles     = 0;
    int         burst_left = 1;

    dual_stepper_timed_half_step_driver dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .left_steps  (left_steps),
        .right_steps (right_steps),
        .duration_us (duration_us),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .left_coils  (left_coils),
        .right_coils (right_coils),
        .left_busy   (left_busy),
        .right_busy  (right_busy),
        .moving      (moving),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        case ((cycles / 256) % 4)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 99) < 30);
            2:       out_stall <= ($urandom_range(0, 99) < 80);
            default: out_stall <= ((cycles % 16) < 5);
        endcase
    end

    function automatic logic [COIL_W-1:0] half_step_pattern(logic [2:0] ph);
        case (ph)
            3'd0:    return 4'd8;
            3'd1:    return 4'd12;
            3'd2:    return 4'd4;
            3'd3:    return 4'd6;
            3'd4:    return 4'd2;
            3'd5:    return 4'd3;
            3'd6:    return 4'd1;
            default: return 4'd9;
        endcase
    endfunction

    function automatic motor_t motor_halt(motor_t m);
        m.dir     = DIR_STOP;
        m.drive   = '0;
        m.count   = '0;
        m.elapsed = '0;
        return m;
    endfunction

    function automatic motor_t motor_load(motor_t m, logic [STEPS_W-1:0] raw,
                                          logic [DUR_W-1:0] dur, logic invert);
        logic [STEPS_W-1:0] mag;
        logic [63:0]        num;
        logic [63:0]        quo;
        logic               neg;
        if (raw == '0)
            return motor_halt(m);
        neg = raw[STEPS_W-1];
        mag = neg ? -raw : raw;
        num = {32'd0, dur} * 64'd2 + 64'(mag);
        quo = num / (64'(mag) * 64'd2);
        if (quo < 64'd1)
            quo = 64'd1;
        if (quo > 64'hFFFF_FFFF)
            quo = 64'hFFFF_FFFF;
        m.period  = quo[DUR_W-1:0];
        m.target  = mag;
        m.count   = '0;
        m.elapsed = '0;
        m.dir     = (neg ^ invert) ? DIR_REV : DIR_FWD;
        return m;
    endfunction

    function automatic motor_t motor_advance(motor_t m);
        if (m.dir == DIR_STOP)
            return m;
        m.elapsed = m.elapsed + 1'b1;
        if (m.elapsed < m.period)
            return m;
        m.elapsed = '0;
        if (m.count >= m.target)
        begin
            m.dir   = DIR_STOP;
            m.drive = '0;
            return m;
        end
        m.count = m.count + 1'b1;
        m.drive = half_step_pattern(m.phase);
        m.phase = (m.dir == DIR_FWD) ? m.phase + 3'd1 : m.phase - 3'd1;
        return m;
    endfunction

    function automatic coil_word_t predict_coils(op_t o, logic [STEPS_W-1:0] l,
                                                 logic [STEPS_W-1:0] r,
                                                 logic [DUR_W-1:0] dur);
        coil_word_t w;
        case (o)
            OP_TICK:
            begin
                left_m  = motor_advance(left_m);
                right_m = motor_advance(right_m);
            end
            OP_MOVE:
            begin
                left_m  = motor_load(left_m, l, dur, 1'b0);
                right_m = motor_load(right_m, r, dur, mirror_right);
            end
            OP_STOP:
            begin
                left_m  = motor_halt(left_m);
                right_m = motor_halt(right_m);
            end
            default: ;
        endcase
        w.left_coils  = left_m.drive;
        w.right_coils = right_m.drive;
        w.left_busy   = (left_m.dir != DIR_STOP);
        w.right_busy  = (right_m.dir != DIR_STOP);
        w.moving      = w.left_busy || w.right_busy;
        return w;
    endfunction

    function automatic void note_mismatch(string what, coil_word_t want, coil_word_t got);
        mismatches = mismatches + 1;
        if (mismatches <= MAX_REPORTS)
            $display("%0t %s: expected L=%h R=%h busy %b%b mov %b, got L=%h R=%h busy %b%b mov %b",
                     $time, what, want.left_coils, want.right_coils, want.left_busy,
                     want.right_busy, want.moving, got.left_coils, got.right_coils,
                     got.left_busy, got.right_busy, got.moving);
    endfunction

    always @(posedge clk)
    begin : check_words
        coil_word_t got;
        coil_word_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got = {left_coils, right_coils, left_busy, right_busy, moving};
            if (coil_words_q.size() == 0)
                note_mismatch("word with nothing pending", '0, got);
            else
            begin
                want = coil_words_q.pop_front();
                if (got.left_coils !== want.left_coils || got.right_coils !== want.right_coils
                    || got.left_busy !== want.left_busy || got.right_busy !== want.right_busy
                    || got.moving !== want.moving)
                    note_mismatch("word differs", want, got);
            end
        end
    end

    function automatic logic [STEPS_W-1:0] any_count();
        logic [31:0] t;
        t = $urandom;
        return t[STEPS_W-1:0];
    endfunction

    function automatic logic [STEPS_W-1:0] short_travel();
        int v;
        v = int'($urandom_range(0, 12)) - 6;
        return v[STEPS_W-1:0];
    endfunction

    task automatic send_command(op_t o, logic [STEPS_W-1:0] l, logic [STEPS_W-1:0] r,
                                logic [DUR_W-1:0] dur);
        int gap;
        in_valid    <= 1'b1;
        op          <= o;
        left_steps  <= l;
        right_steps <= r;
        duration_us <= dur;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        coil_words_q.push_back(predict_coils(o, l, r, dur));
        burst_left = burst_left - 1;
        if (burst_left <= 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (coil_words_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mirror(logic v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid    <= 1'b0;
        mirror_right = v;
    endtask

    task automatic run_motion(int n);
        int sent;
        int kind;
        int ticks;
        int dur;
        sent = 0;
        while (sent < n)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 72)
            begin
                dur = $urandom_range(0, 40);
                send_command(OP_MOVE, short_travel(), short_travel(), dur);
                sent++;
                ticks = $urandom_range(dur / 2, 2 * dur + 6);
                repeat (ticks)
                begin
                    if ($urandom_range(0, 99) < 3)
                        send_command(OP_STOP, any_count(), any_count(), $urandom);
                    else if ($urandom_range(0, 99) < 3)
                        send_command(OP_NONE, any_count(), any_count(), $urandom);
                    else
                        send_command(OP_TICK, any_count(), any_count(), $urandom);
                    sent++;
                end
            end
            else if (kind < 82)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_command(OP_MOVE, any_count(), any_count(), $urandom);
                else
                    send_command(OP_MOVE, any_count(), any_count(), $urandom_range(0, 100));
                sent++;
                repeat ($urandom_range(1, 12))
                begin
                    send_command(OP_TICK, any_count(), any_count(), $urandom);
                    sent++;
                end
            end
            else if (kind < 90)
            begin
                send_command(OP_STOP, any_count(), any_count(), $urandom);
                sent++;
            end
            else if (kind < 95)
                send_command(OP_NONE, any_count(), any_count(), $urandom);
            else
            begin
                repeat ($urandom_range(1, 10))
                begin
                    send_command(OP_TICK, any_count(), any_count(), $urandom);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_idle_ops();
        send_command(OP_TICK, '0, '0, '0);
        send_command(OP_NONE, '1, '1, '1);
        send_command(OP_STOP, 24'h5A5A5A, 24'hA5A5A5, 32'hDEAD_BEEF);
    endtask

    task automatic test_field_extremes();
        send_command(OP_MOVE, 24'h7FFFFF, 24'h800001, 32'hFFFF_FFFF);
        send_command(OP_TICK, '0, '0, '0);
        send_command(OP_MOVE, 24'd1, 24'h7FFFFF, 32'hFFFF_FFFF);
        send_command(OP_MOVE, 24'h800000, 24'd1, 32'd0);
        send_command(OP_TICK, '1, '1, '1);
        send_command(OP_TICK, '0, '0, '0);
        send_command(OP_MOVE, '0, '0, 32'h1234_5678);
    endtask

    task automatic test_single_steps();
        send_command(OP_MOVE, 24'd1, -24'sd1, 32'd1);
        repeat (3) send_command(OP_TICK, '0, '0, '0);
        // half-tick interval rounds up on the left
        send_command(OP_MOVE, 24'd2, 24'd3, 32'd3);
        repeat (4) send_command(OP_TICK, '0, '0, '0);
        send_command(OP_MOVE, '0, -24'sd2, 32'd4);
        repeat (2) send_command(OP_TICK, '0, '0, '0);
        send_command(OP_STOP, '0, '0, '0);
    endtask

    task automatic test_mirror_setting(logic v, int n);
        write_mirror(v);
        run_motion(n);
    endtask

    initial
    begin
        left_m         = '0;
        left_m.period  = 1;
        right_m        = '0;
        right_m.period = 1;
        mirror_right   = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_ops();
        test_field_extremes();
        test_single_steps();
        test_mirror_setting(1'b0, 440);
        test_mirror_setting(1'b1, 440);
        test_mirror_setting(1'b0, 440);
        test_mirror_setting(1'b1, 440);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && coil_words_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
